/* hw/rtl/arqr_pkg.sv */
// ============================================================================
// arqr_pkg
// Shared types and constants of the ARQ receiver: input codes, register
// indexes, reset values and the command word passed from front to back.
// ============================================================================
package arqr_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic CFG_REQUEST_CHAR = 1'b0;
    localparam logic CFG_TIMEOUT      = 1'b1;

    localparam logic [7:0]  REQUEST_CHAR_RESET  = 8'd48;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload;
        logic       has_frame;
        logic       is_ack;
        logic [7:0] value;
    } cmd_t;

endpackage

/* hw/rtl/arqr_front.sv */
// ============================================================================
// arqr_front
// Accepts input words, tracks packet and timer state and issues one command
// per input word that causes output.
// ============================================================================
module arqr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              s_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              fifo_full,
    output logic              push,
    output arqr_pkg::cmd_t    push_cmd
);
    import arqr_pkg::*;

    logic [7:0]  request_char_reg, request_char_next;
    logic [15:0] timeout_ticks_reg, timeout_ticks_next;
    logic [1:0]  byte_position_reg, byte_position_next;
    logic [7:0]  expected_number_reg, expected_number_next;
    logic [7:0]  total_count_reg, total_count_next;
    logic [7:0]  packet_number_reg, packet_number_next;
    logic        in_order_reg, in_order_next;
    logic        saved_is_ack_reg, saved_is_ack_next;
    logic [7:0]  saved_value_reg, saved_value_next;
    logic [15:0] timer_count_reg, timer_count_next;
    logic        timer_running_reg, timer_running_next;

    logic        accept;
    logic        ord_v;
    logic [7:0]  tot_v;
    logic [7:0]  exp_v;
    logic [16:0] tick_v;
    cmd_t        cmd;

    assign s_tready  = !fifo_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        request_char_next    = request_char_reg;
        timeout_ticks_next   = timeout_ticks_reg;
        byte_position_next   = byte_position_reg;
        expected_number_next = expected_number_reg;
        total_count_next     = total_count_reg;
        packet_number_next   = packet_number_reg;
        in_order_next        = in_order_reg;
        saved_is_ack_next    = saved_is_ack_reg;
        saved_value_next     = saved_value_reg;
        timer_count_next     = timer_count_reg;
        timer_running_next   = timer_running_reg;
        ord_v  = in_order_reg;
        tot_v  = total_count_reg;
        exp_v  = expected_number_reg + {7'd0, in_order_reg};
        tick_v = {1'b0, timer_count_reg} + 17'd1;
        cmd    = '0;
        cmd.payload = s_tdata;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REQUEST_CHAR: request_char_next  = cfg_data[7:0];
                CFG_TIMEOUT:      timeout_ticks_next = cfg_data;
                default:          request_char_next  = request_char_reg;
            endcase
        end

        if (accept)
        begin
            unique case (s_tuser)
                OP_BYTE:
                begin
                    if (byte_position_reg == 2'd1)
                    begin
                        packet_number_next = s_tdata;
                    end
                    if (byte_position_reg == 2'd2)
                    begin
                        if (total_count_reg == 8'd0)
                        begin
                            tot_v = s_tdata;
                        end
                        ord_v = (packet_number_reg == expected_number_reg);
                    end
                    if (byte_position_reg == 2'd3 && ord_v)
                    begin
                        cmd.has_payload = 1'b1;
                    end
                    total_count_next = tot_v;
                    in_order_next    = ord_v;
                    exp_v = expected_number_reg + {7'd0, ord_v};
                    if (s_tlast)
                    begin
                        if (byte_position_reg >= 2'd2)
                        begin
                            expected_number_next = exp_v;
                            saved_is_ack_next    = 1'b1;
                            saved_value_next     = exp_v - 8'd1;
                            cmd.has_frame        = 1'b1;
                            timer_count_next     = 16'd0;
                            timer_running_next   = (exp_v <= tot_v);
                        end
                        byte_position_next = 2'd0;
                        in_order_next      = 1'b0;
                    end
                    else if (byte_position_reg != 2'd3)
                    begin
                        byte_position_next = byte_position_reg + 2'd1;
                    end
                end
                OP_TICK:
                begin
                    if (timer_running_reg)
                    begin
                        if (tick_v >= {1'b0, timeout_ticks_reg})
                        begin
                            cmd.has_frame    = 1'b1;
                            timer_count_next = 16'd0;
                        end
                        else
                        begin
                            timer_count_next = tick_v[15:0];
                        end
                    end
                end
                OP_START:
                begin
                    saved_is_ack_next  = 1'b0;
                    saved_value_next   = request_char_reg;
                    cmd.has_frame      = 1'b1;
                    timer_count_next   = 16'd0;
                    timer_running_next = 1'b1;
                end
                default:
                begin
                    cmd.has_frame = 1'b0;
                end
            endcase
        end

        cmd.is_ack = saved_is_ack_next;
        cmd.value  = saved_value_next;
    end

    assign push     = accept && (cmd.has_payload || cmd.has_frame);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_char_reg    <= REQUEST_CHAR_RESET;
            timeout_ticks_reg   <= TIMEOUT_TICKS_RESET;
            byte_position_reg   <= 2'd0;
            expected_number_reg <= 8'd1;
            total_count_reg     <= 8'd0;
            packet_number_reg   <= 8'd0;
            in_order_reg        <= 1'b0;
            saved_is_ack_reg    <= 1'b0;
            saved_value_reg     <= 8'd0;
            timer_count_reg     <= 16'd0;
            timer_running_reg   <= 1'b0;
        end
        else
        begin
            request_char_reg    <= request_char_next;
            timeout_ticks_reg   <= timeout_ticks_next;
            byte_position_reg   <= byte_position_next;
            expected_number_reg <= expected_number_next;
            total_count_reg     <= total_count_next;
            packet_number_reg   <= packet_number_next;
            in_order_reg        <= in_order_next;
            saved_is_ack_reg    <= saved_is_ack_next;
            saved_value_reg     <= saved_value_next;
            timer_count_reg     <= timer_count_next;
            timer_running_reg   <= timer_running_next;
        end
    end

endmodule

/* hw/rtl/arqr_cmd_fifo.sv */
// ============================================================================
// arqr_cmd_fifo
// Short command queue between the front and the back of the receiver.
// ============================================================================
module arqr_cmd_fifo #(
    parameter int DEPTH = arqr_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  arqr_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output arqr_pkg::cmd_t    head,
    output logic              empty,
    output logic              full
);
    import arqr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head  = entries[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/arqr_back.sv */
// ============================================================================
// arqr_back
// Expands queued commands into output words: a payload word for the host,
// a five-word ACK or GET frame for the transmitter, or both, payload first.
// ============================================================================
module arqr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  arqr_pkg::cmd_t    head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [0:0]        m_tuser,
    output logic              m_tlast
);
    import arqr_pkg::*;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_T = 8'h54;

    typedef enum logic [2:0] {
        PH_PAY,
        PH_F0,
        PH_F1,
        PH_F2,
        PH_F3,
        PH_F4
    } phase_t;

    phase_t     phase_reg;
    phase_t     ph;
    phase_t     ph_after;
    logic       active_reg;
    cmd_t       cur_reg;
    cmd_t       sel;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;
    logic       step;
    logic       done;
    logic [7:0] word_byte;
    logic       word_dest;
    logic       word_last;
    logic [7:0] l1;
    logic [7:0] l2;
    logic [7:0] l3;

    assign sel  = active_reg ? cur_reg : head;
    assign ph   = active_reg ? phase_reg : (head.has_payload ? PH_PAY : PH_F0);
    assign step = (active_reg || !empty) && (!m_tvalid_reg || m_tready);
    assign pop  = step && !active_reg;
    assign done = (ph == PH_F4) || (ph == PH_PAY && !sel.has_frame);

    assign l1 = sel.is_ack ? CH_A : CH_G;
    assign l2 = sel.is_ack ? CH_C : CH_E;
    assign l3 = sel.is_ack ? CH_K : CH_T;

    always_comb
    begin
        word_dest = 1'b1;
        word_last = 1'b0;
        word_byte = sel.value;
        ph_after  = PH_F0;
        unique case (ph)
            PH_PAY:
            begin
                word_dest = 1'b0;
                word_last = !sel.has_frame;
                word_byte = sel.payload;
                ph_after  = PH_F0;
            end
            PH_F0:
            begin
                word_byte = l1 ^ l2 ^ l3 ^ sel.value;
                ph_after  = PH_F1;
            end
            PH_F1:
            begin
                word_byte = l1;
                ph_after  = PH_F2;
            end
            PH_F2:
            begin
                word_byte = l2;
                ph_after  = PH_F3;
            end
            PH_F3:
            begin
                word_byte = l3;
                ph_after  = PH_F4;
            end
            PH_F4:
            begin
                word_byte = sel.value;
                word_last = 1'b1;
                ph_after  = PH_F0;
            end
            default:
            begin
                word_byte = sel.value;
                ph_after  = PH_F0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PAY;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= ph_after;
            active_reg   <= !done;
            cur_reg      <= sel;
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= word_byte;
            m_tuser_reg  <= word_dest;
            m_tlast_reg  <= word_last;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

/* hw/rtl/arq_receiver_with_ack_timer.sv */
// ============================================================================
// arq_receiver_with_ack_timer
// Stop-and-wait ARQ receiver with cumulative ACK frames and a resend timer.
// ============================================================================
// The slave stream carries one input word per transfer: received packet
// bytes (tuser 0, tlast on the final byte), timer ticks (tuser 1) and start
// requests (tuser 2). The master stream delivers payload bytes for the host
// (tuser 0) and frame bytes for the transmitter (tuser 1); tlast marks the
// final output word caused by one input word.
// The configuration channel writes the GET request character (index 0) and
// the resend timeout in ticks (index 1); it is always ready.
// The front accepts one word per cycle while the queue is not full and pushes
// a command into a queue of FIFO_DEPTH entries; the back registers and emits
// one output word per cycle while the master is ready, so a packet end with
// payload gives six words. The rate is set by the back's single output port:
// a long ACK burst fills the queue and tready drops.
// Reset returns the packet and timer state and both registers to their
// initial values and empties the queue. When the master stalls, the output
// word holds and the queue absorbs input until it is full.
// ============================================================================
module arq_receiver_with_ack_timer #(
    parameter int FIFO_DEPTH = arqr_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic [1:0]  s_tuser,   // op
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic [0:0]  m_tuser,   // dest
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import arqr_pkg::*;

    logic fifo_full;
    logic fifo_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head;

    arqr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    arqr_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    arqr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (fifo_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/arqr_checker.sv */
// ============================================================================
// arqr_checker
// Port-level checks of the ARQ receiver, bound to the top level.
// ============================================================================
module arqr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_index,
    input logic [15:0] cfg_data
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("Output word valid during reset.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("Stalled output word changed.");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0])
        else $error("An unfinished run was not followed by a frame word.");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("Configuration write was refused.");

endmodule

bind arq_receiver_with_ack_timer arqr_checker u_checker (.*);

/* tb/arq_receiver_with_ack_timer_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// arq_receiver_with_ack_timer_test
// Self-checking bench for the ARQ receiver. A cycle-free model of the packet
// parser, the cumulative ACK and GET frames and the resend timer predicts
// every output word; a monitor compares each output word with the oldest
// prediction. Directed words cover short packets, the unused code, idle
// ticks and interleaving; timer settings, a long output stall, random packets
// and a run of consecutive in-order packets follow.
// ============================================================================
module arq_receiver_with_ack_timer_test;

    import arqr_pkg::*;

    localparam logic [1:0] OP_RESERVED      = 2'd3;
    localparam logic [7:0] CH_A             = "A";
    localparam logic [7:0] CH_C             = "C";
    localparam logic [7:0] CH_K             = "K";
    localparam logic [7:0] CH_G             = "G";
    localparam logic [7:0] CH_E             = "E";
    localparam logic [7:0] CH_T             = "T";
    localparam int         RANDOM_WORDS     = 250;
    localparam int         IN_ORDER_PACKETS = 50;
    localparam int         SETTLE_CYCLES    = 10;
    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         LONG_HOLD        = 300;

    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       tail;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // rx_byte
    logic [1:0]  s_tuser;   // op
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic [0:0]  m_tuser;   // dest
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    logic [1:0]  rx_pos;
    logic [7:0]  next_seq;
    logic [7:0]  total_latched;
    logic [7:0]  pkt_seq;
    logic        seq_match;
    logic        resend_is_ack;
    logic [7:0]  resend_value;
    logic [15:0] tick_count;
    logic        timer_on;
    logic [7:0]  req_char;
    logic [15:0] timeout_cfg;

    out_word_t   expected_out[$];
    out_word_t   burst[$];
    int          errors;
    int          words_sent;
    int          idle_cycles;
    int          hold_request;
    logic        idle_on;

    arq_receiver_with_ack_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void put_byte(input logic dest, input logic [7:0] b);
        out_word_t w;
        w.dest = dest;
        w.data = b;
        w.tail = 1'b0;
        burst.push_back(w);
    endfunction

    function automatic void put_frame();
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        if (resend_is_ack)
        begin
            c1 = CH_A;
            c2 = CH_C;
            c3 = CH_K;
        end
        else
        begin
            c1 = CH_G;
            c2 = CH_E;
            c3 = CH_T;
        end
        put_byte(1'b1, c1 ^ c2 ^ c3 ^ resend_value);
        put_byte(1'b1, c1);
        put_byte(1'b1, c2);
        put_byte(1'b1, c3);
        put_byte(1'b1, resend_value);
    endfunction

    function automatic void predict_word(input logic [1:0] op, input logic [7:0] b,
                                         input logic lst);
        logic [1:0] pos;
        logic [16:0] cnt;
        out_word_t w;
        burst.delete();
        case (op)
            OP_BYTE:
            begin
                pos = rx_pos;
                if (pos == 2'd1)
                    pkt_seq = b;
                else if (pos == 2'd2)
                begin
                    if (total_latched == 8'd0)
                        total_latched = b;
                    seq_match = (pkt_seq == next_seq);
                end
                else if (pos == 2'd3 && seq_match)
                    put_byte(1'b0, b);
                if (lst)
                begin
                    if (pos >= 2'd2)
                    begin
                        if (seq_match)
                            next_seq = next_seq + 8'd1;
                        resend_is_ack = 1'b1;
                        resend_value = next_seq - 8'd1;
                        put_frame();
                        tick_count = 16'd0;
                        timer_on = (next_seq <= total_latched);
                    end
                    rx_pos = 2'd0;
                    seq_match = 1'b0;
                end
                else if (pos < 2'd3)
                    rx_pos = pos + 2'd1;
            end
            OP_TICK:
            begin
                if (timer_on)
                begin
                    cnt = {1'b0, tick_count} + 17'd1;
                    if (cnt >= {1'b0, timeout_cfg})
                    begin
                        put_frame();
                        tick_count = 16'd0;
                    end
                    else
                        tick_count = cnt[15:0];
                end
            end
            OP_START:
            begin
                resend_is_ack = 1'b0;
                resend_value = req_char;
                put_frame();
                tick_count = 16'd0;
                timer_on = 1'b1;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < burst.size(); i++)
        begin
            w = burst[i];
            w.tail = (i == burst.size() - 1);
            expected_out.push_back(w);
        end
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        predict_word(op, b, lst);
        if (op != OP_RESERVED)
            words_sent++;
    endtask

    task automatic send_packet(input int len, input bit keep_order, input bit mixed);
        logic [7:0] b;
        logic [1:0] extra_op;
        int r;
        for (int i = 0; i < len; i++)
        begin
            if (i == 1 && keep_order)
                b = next_seq;
            else
                b = 8'($urandom);
            if (mixed && i > 0 && $urandom_range(0, 9) == 0)
            begin
                r = $urandom_range(0, 2);
                extra_op = (r == 0) ? OP_TICK : (r == 1) ? OP_START : OP_RESERVED;
                send_word(extra_op, 8'($urandom), 1'($urandom));
            end
            send_word(OP_BYTE, b, i == len - 1);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_REQUEST_CHAR)
            req_char = value[7:0];
        else
            timeout_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_word(OP_TICK, 8'h00, 1'b0);
        send_word(OP_RESERVED, 8'hFF, 1'b1);
        send_word(OP_BYTE, 8'hFF, 1'b1);
        send_word(OP_BYTE, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'hFF, 1'b1);
        send_word(OP_BYTE, 8'hA5, 1'b0);
        send_word(OP_BYTE, 8'h01, 1'b0);
        send_word(OP_BYTE, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'hFF, 1'b1);
        send_word(OP_TICK, 8'hFF, 1'b1);
        send_word(OP_START, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'h3C, 1'b0);
        send_word(OP_BYTE, 8'h55, 1'b0);
        send_word(OP_BYTE, 8'h03, 1'b0);
        send_word(OP_TICK, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'hAA, 1'b0);
        send_word(OP_START, 8'hFF, 1'b1);
        send_word(OP_BYTE, 8'h0F, 1'b1);
        send_word(OP_BYTE, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'h02, 1'b0);
        send_word(OP_BYTE, 8'hFF, 1'b1);
    endtask

    task automatic test_timer_settings();
        write_register(CFG_TIMEOUT, 16'd0);
        send_word(OP_TICK, 8'h00, 1'b0);
        send_word(OP_TICK, 8'h00, 1'b0);
        write_register(CFG_TIMEOUT, 16'd1);
        send_word(OP_TICK, 8'h00, 1'b0);
        write_register(CFG_REQUEST_CHAR, 16'h0000);
        send_word(OP_START, 8'h00, 1'b0);
        write_register(CFG_REQUEST_CHAR, 16'h00FF);
        send_word(OP_START, 8'h00, 1'b0);
        write_register(CFG_TIMEOUT, 16'd3);
        repeat (7) send_word(OP_TICK, 8'h00, 1'b0);
        write_register(CFG_TIMEOUT, 16'hFFFF);
        send_word(OP_START, 8'h00, 1'b0);
        repeat (3) send_word(OP_TICK, 8'h00, 1'b0);
        write_register(CFG_TIMEOUT, 16'd2);
    endtask

    task automatic test_backpressure();
        wait_for_results();
        idle_on <= 1'b0;
        hold_request <= LONG_HOLD;
        repeat (4) send_packet(5, 1'b1, 1'b0);
        wait_for_results();
        idle_on <= 1'b1;
    endtask

    task automatic test_random();
        int r;
        int len;
        int n;
        int stop_at;
        int next_reconfig;
        stop_at = words_sent + RANDOM_WORDS;
        next_reconfig = words_sent + 90;
        while (words_sent < stop_at)
        begin
            idle_on <= ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 68)
            begin
                n = $urandom_range(0, 19);
                if (n < 2)
                    len = $urandom_range(1, 2);
                else if (n < 3)
                    len = $urandom_range(9, 20);
                else
                    len = $urandom_range(3, 8);
                send_packet(len, $urandom_range(0, 3) != 0, 1'b1);
            end
            else if (r < 84)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_word(OP_TICK, 8'($urandom), 1'($urandom));
            end
            else if (r < 92)
                send_word(OP_START, 8'($urandom), 1'($urandom));
            else
                send_word(OP_RESERVED, 8'($urandom), 1'($urandom));
            if (words_sent >= next_reconfig)
            begin
                n = $urandom_range(0, 9);
                if (n == 0)
                    write_register(CFG_TIMEOUT, 16'd0);
                else if (n == 1)
                    write_register(CFG_TIMEOUT, 16'hFFFF);
                else
                    write_register(CFG_TIMEOUT, 16'($urandom_range(1, 6)));
                write_register(CFG_REQUEST_CHAR, {8'h00, 8'($urandom)});
                next_reconfig = words_sent + 90;
            end
        end
    endtask

    task automatic test_in_order_run();
        for (int i = 0; i < IN_ORDER_PACKETS; i++)
        begin
            idle_on <= ($urandom_range(0, 3) != 0);
            send_packet(3, 1'b1, 1'b0);
            if ($urandom_range(0, 15) == 0)
                send_word(OP_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    always @(posedge clk)
    begin : output_monitor
        logic nxt;
        int rx_gap;
        int hold_left;
        out_word_t exp_w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual dest %0d byte %02h last %0d",
                             $time, m_tuser[0], m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    exp_w = expected_out.pop_front();
                    if (exp_w.dest !== m_tuser[0])
                    begin
                        $display("%0t: dest mismatch, expected %0d, actual %0d",
                                 $time, exp_w.dest, m_tuser[0]);
                        errors++;
                    end
                    if (exp_w.data !== m_tdata)
                    begin
                        $display("%0t: byte mismatch, expected %02h, actual %02h",
                                 $time, exp_w.data, m_tdata);
                        errors++;
                    end
                    if (exp_w.tail !== m_tlast)
                    begin
                        $display("%0t: last mismatch, expected %0d, actual %0d",
                                 $time, exp_w.tail, m_tlast);
                        errors++;
                    end
                end
                rx_gap = idle_on ? $urandom_range(0, 13) : 0;
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request <= 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                nxt = 1'b0;
            end
            else
                nxt = 1'b1;
            m_tready <= nxt;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = OP_BYTE;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_REQUEST_CHAR;
        cfg_data     = 16'h0000;
        errors       = 0;
        words_sent   = 0;
        idle_cycles  = 0;
        hold_request = 0;
        idle_on      = 1'b1;
        rx_pos        = 2'd0;
        next_seq      = 8'd1;
        total_latched = 8'd0;
        pkt_seq       = 8'd0;
        seq_match     = 1'b0;
        resend_is_ack = 1'b0;
        resend_value  = 8'd0;
        tick_count    = 16'd0;
        timer_on      = 1'b0;
        req_char      = REQUEST_CHAR_RESET;
        timeout_cfg   = TIMEOUT_TICKS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_timer_settings();
        test_backpressure();
        test_random();
        test_in_order_run();

        wait_for_results();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_out.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/arqr_pkg.sv
hw/rtl/arqr_front.sv
hw/rtl/arqr_cmd_fifo.sv
hw/rtl/arqr_back.sv
hw/rtl/arq_receiver_with_ack_timer.sv
hw/rtl/arqr_checker.sv
tb/arq_receiver_with_ack_timer_test.sv
